/* src/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions for the text console writer
// Screen geometry, derived widths, character codes, command kinds and the
// structs that pass between the cursor unit and the top level.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    localparam int OFF_W = $clog2(CELL_COUNT);
    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLUMNS);

    localparam int KIND_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int ADDR_W  = 11;
    localparam int CURS_W  = 11;

    localparam logic [ATTR_W-1:0] RESET_ATTR     = 8'h0A;
    localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;
    localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CODE_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;

    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    typedef logic [OFF_W-1:0]         t_offset;
    typedef logic [ATTR_W+CHAR_W-1:0] t_cell;

    // Command from the sequencer to the cursor unit.
    typedef struct packed {
        logic              put;
        logic              home;
        logic [CHAR_W-1:0] code;
    } t_cur_cmd;

    // What a put of the presented character does to the screen store.
    typedef struct packed {
        logic    wr_en;
        logic    wr_blank;
        t_offset wr_addr;
        logic    scroll;
    } t_put_eff;

endpackage

/* src/text_console_writer_unit.sv */
// ----------------------------------------------------------------------------
// text_console_writer_unit: character cell console with cursor
// Keeps the screen cells in one memory and executes put, clear and read
// commands against it, one command at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the s_axis channel, kind in tuser, character and cell
//   address in tdata. Every command gives exactly one result transfer on the
//   m_axis channel: the cursor offset and, for a read, the addressed cell.
//   The attribute byte is written on the cfg channel, which is always ready.
//   Steps, from the accepting edge to the result being presented:
//     put without scroll, unused kind : a response state
//     read                            : a registered memory read
//     put that scrolls                : the copy walks the store at one cell
//                                       per cycle on the single write port,
//                                       then blanks the bottom row
//     clear                           : a blanking sweep over every cell
//   A command holds tready low until its result is presented, so a new
//   command is never taken while an older one is still running.
//   After reset the store is swept to blanks with attribute 0x0A, one cell per
//   cycle, with tready low; cfg writes are still taken.
//   The result sits in an output register; a stalled receiver holds it, and
//   the next command is accepted on the same edge that the result is taken.
// ----------------------------------------------------------------------------
module text_console_writer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Commands
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // char_code[7:0], cell_address[18:8], zero pad
    input  logic [1:0]  i_s_axis_tuser,   // kind[1:0]
    // Results
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // cursor_offset[10:0], cell_char[18:11],
                                          // cell_attribute[26:19], zero pad
    // Attribute register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);
    import tcw_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RESP = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_SCR  = 3'd3;
    localparam logic [2:0] ST_SDRN = 3'd4;
    localparam logic [2:0] ST_BLK  = 3'd5;
    localparam logic [2:0] ST_FILL = 3'd6;

    localparam t_offset LAST_CELL = OFF_W'(CELL_COUNT - 1);
    localparam t_offset LAST_ROW  = OFF_W'(CELL_COUNT - COLUMNS);

    logic [2:0]        r_state, n_state;
    t_offset           r_ptr, n_ptr;
    logic              r_cp_vld, n_cp_vld;
    t_offset           r_cp_dst, n_cp_dst;
    logic [ATTR_W-1:0] r_attr;
    logic [ATTR_W-1:0] r_fill_attr, n_fill_attr;
    logic              r_fill_resp, n_fill_resp;
    logic              r_rd_ok, n_rd_ok;
    logic              r_out_valid, n_out_valid;
    logic [CURS_W-1:0] r_out_curs, n_out_curs;
    logic [CHAR_W-1:0] r_out_char, n_out_char;
    logic [ATTR_W-1:0] r_out_attr, n_out_attr;

    logic [KIND_W-1:0] in_kind;
    logic [CHAR_W-1:0] in_char;
    logic [ADDR_W-1:0] in_addr;
    logic              accept;

    t_cur_cmd cur_cmd;
    t_put_eff put_eff;
    t_offset  cur_offset;

    logic    mem_we;
    t_offset mem_waddr;
    t_cell   mem_wdata;
    t_offset mem_raddr;
    t_cell   mem_rdata;

    assign in_kind = i_s_axis_tuser;
    assign in_char = i_s_axis_tdata[7:0];
    assign in_addr = i_s_axis_tdata[18:8];

    assign o_s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    assign cur_cmd.put  = accept && (in_kind == KIND_PUT);
    assign cur_cmd.home = accept && (in_kind == KIND_CLEAR);
    assign cur_cmd.code = in_char;

    tcw_cursor u_cursor (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cur_cmd),
        .o_eff    (put_eff),
        .o_offset (cur_offset)
    );

    tcw_cell_mem u_cells (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Write port: the scroll copy, the blanking sweeps and a put's cell write
    // never fall in the same cycle.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_ptr;
        mem_wdata = {r_attr, BLANK_CHAR};
        priority if (r_cp_vld) begin
            mem_we    = 1'b1;
            mem_waddr = r_cp_dst;
            mem_wdata = mem_rdata;
        end else if (r_state == ST_FILL) begin
            mem_we    = 1'b1;
            mem_wdata = {r_fill_attr, BLANK_CHAR};
        end else if (r_state == ST_BLK) begin
            mem_we    = 1'b1;
        end else if (cur_cmd.put && put_eff.wr_en) begin
            mem_we    = 1'b1;
            mem_waddr = put_eff.wr_addr;
            mem_wdata = {r_attr, put_eff.wr_blank ? BLANK_CHAR : in_char};
        end
    end

    assign mem_raddr = (r_state == ST_SCR) ? r_ptr : OFF_W'(in_addr);

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_cp_vld    = 1'b0;
        n_cp_dst    = r_cp_dst;
        n_fill_attr = r_fill_attr;
        n_fill_resp = r_fill_resp;
        n_rd_ok     = r_rd_ok;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_curs  = r_out_curs;
        n_out_char  = r_out_char;
        n_out_attr  = r_out_attr;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (in_kind)
                        KIND_PUT: begin
                            if (put_eff.scroll) begin
                                n_ptr   = OFF_W'(COLUMNS);
                                n_state = ST_SCR;
                            end else begin
                                n_state = ST_RESP;
                            end
                        end
                        KIND_CLEAR: begin
                            n_ptr       = '0;
                            n_fill_attr = r_attr;
                            n_fill_resp = 1'b1;
                            n_state     = ST_FILL;
                        end
                        KIND_READ: begin
                            n_rd_ok = (int'(in_addr) < CELL_COUNT);
                            n_state = ST_READ;
                        end
                        default: begin
                            n_state = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SCR: begin
                // Cell at r_ptr moves up one row; its data lands next cycle.
                n_cp_vld = 1'b1;
                n_cp_dst = r_ptr - OFF_W'(COLUMNS);
                if (r_ptr == LAST_CELL) begin
                    n_state = ST_SDRN;
                end else begin
                    n_ptr = r_ptr + OFF_W'(1);
                end
            end
            ST_SDRN: begin
                n_ptr   = LAST_ROW;
                n_state = ST_BLK;
            end
            ST_BLK: begin
                if (r_ptr == LAST_CELL) begin
                    n_state = ST_RESP;
                end else begin
                    n_ptr = r_ptr + OFF_W'(1);
                end
            end
            ST_FILL: begin
                if (r_ptr == LAST_CELL) begin
                    n_state = r_fill_resp ? ST_RESP : ST_IDLE;
                end else begin
                    n_ptr = r_ptr + OFF_W'(1);
                end
            end
            ST_RESP: begin
                n_out_valid = 1'b1;
                n_out_curs  = CURS_W'(cur_offset);
                n_out_char  = '0;
                n_out_attr  = '0;
                n_state     = ST_IDLE;
            end
            ST_READ: begin
                n_out_valid = 1'b1;
                n_out_curs  = CURS_W'(cur_offset);
                n_out_char  = r_rd_ok ? mem_rdata[CHAR_W-1:0] : '0;
                n_out_attr  = r_rd_ok ? mem_rdata[CHAR_W+ATTR_W-1:CHAR_W] : '0;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_ptr       <= '0;
            r_cp_vld    <= 1'b0;
            r_fill_attr <= RESET_ATTR;
            r_fill_resp <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_cp_vld    <= n_cp_vld;
            r_fill_attr <= n_fill_attr;
            r_fill_resp <= n_fill_resp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_dst   <= n_cp_dst;
        r_rd_ok    <= n_rd_ok;
        r_out_curs <= n_out_curs;
        r_out_char <= n_out_char;
        r_out_attr <= n_out_attr;
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= RESET_ATTR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_attr <= i_cfg_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_out_attr, r_out_char, r_out_curs};

    // A copy write is only in flight during the scroll walk or its drain cycle.
    a_copy_in_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_vld |-> (r_state == ST_SDRN || r_state == ST_SCR))
        else $error("scroll copy write outside the scroll walk");

    // A result is only produced into an empty output register.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESP || r_state == ST_READ) |-> !r_out_valid)
        else $error("result would overwrite a pending transfer");

    // The cursor never leaves the screen.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(cur_offset) < CELL_COUNT)
        else $error("cursor offset beyond the last cell");

    // An accepted command always yields exactly one result before the next.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_axis_tready)
        else $error("command accepted while the previous one is still running");

endmodule

/* src/tcw_cell_mem.sv */
// ----------------------------------------------------------------------------
// tcw_cell_mem: screen cell store
// Simple dual-port memory, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_cell_mem (
    input  logic           i_clk,
    input  logic           i_we,
    input  tcw_pkg::t_offset i_waddr,
    input  tcw_pkg::t_cell i_wdata,
    input  tcw_pkg::t_offset i_raddr,
    output tcw_pkg::t_cell o_rdata
);
    import tcw_pkg::*;

    t_cell r_mem [CELL_COUNT];
    t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/tcw_cursor.sv */
// ----------------------------------------------------------------------------
// tcw_cursor: cursor position and put-character decode
// Holds row, column and linear offset, and works out the cell write and the
// scroll request for the character on its command input.
// ----------------------------------------------------------------------------
module tcw_cursor (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcw_pkg::t_cur_cmd  i_cmd,
    output tcw_pkg::t_put_eff  o_eff,
    output tcw_pkg::t_offset   o_offset
);
    import tcw_pkg::*;

    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    t_offset          r_offset, n_offset;

    logic [ROW_W:0]   row_x;
    logic [COL_W:0]   col_x;
    logic [COL_W:0]   tab_x;
    logic [COL_W:0]   inc_x;
    logic             is_bs;
    logic             is_plain;
    logic             scroll;

    always_comb begin
        row_x    = {1'b0, r_row};
        col_x    = {1'b0, r_col};
        tab_x    = (col_x + (COL_W+1)'(4)) & ~(COL_W+1)'(3);
        inc_x    = col_x + (COL_W+1)'(1);
        is_bs    = 1'b0;
        is_plain = 1'b0;

        priority if (i_cmd.code == CODE_NEWLINE) begin
            col_x = '0;
            row_x = row_x + (ROW_W+1)'(1);
        end else if (i_cmd.code == CODE_TAB) begin
            if (tab_x >= (COL_W+1)'(COLUMNS)) begin
                col_x = '0;
                row_x = row_x + (ROW_W+1)'(1);
            end else begin
                col_x = tab_x;
            end
        end else if (i_cmd.code == CODE_BACKSPACE) begin
            is_bs = 1'b1;
            if (r_col == '0) begin
                if (r_row != '0) begin
                    row_x = row_x - (ROW_W+1)'(1);
                    col_x = (COL_W+1)'(COLUMNS - 1);
                end
            end else begin
                col_x = col_x - (COL_W+1)'(1);
            end
        end else begin
            is_plain = 1'b1;
            if (inc_x >= (COL_W+1)'(COLUMNS)) begin
                col_x = '0;
                row_x = row_x + (ROW_W+1)'(1);
            end else begin
                col_x = inc_x;
            end
        end

        // Passing the bottom row keeps the cursor on the last row.
        scroll = (row_x >= (ROW_W+1)'(ROWS));
        if (scroll) begin
            row_x = (ROW_W+1)'(ROWS - 1);
        end

        n_row    = row_x[ROW_W-1:0];
        n_col    = col_x[COL_W-1:0];
        n_offset = OFF_W'(n_row) * OFF_W'(COLUMNS) + OFF_W'(n_col);

        // A backspace blanks the cell it lands on; a plain byte fills the
        // cell under the old cursor.
        o_eff.wr_en    = is_bs || is_plain;
        o_eff.wr_blank = is_bs;
        o_eff.wr_addr  = is_bs ? n_offset : r_offset;
        o_eff.scroll   = scroll;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_col    <= '0;
            r_offset <= '0;
        end else if (i_cmd.home) begin
            r_row    <= '0;
            r_col    <= '0;
            r_offset <= '0;
        end else if (i_cmd.put) begin
            r_row    <= n_row;
            r_col    <= n_col;
            r_offset <= n_offset;
        end
    end

    assign o_offset = r_offset;

endmodule

/* tb/tcw_checker.sv */
// ----------------------------------------------------------------------------
// tcw_checker: result predictor and scoreboard for the text console writer
// Watches the command, result and attribute channels. It keeps its own copy
// of the screen, cursor and attribute, predicts the result of every accepted
// command, and compares each result transfer field by field, in order.
// ----------------------------------------------------------------------------
module tcw_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // char_code[7:0], cell_address[18:8], zero pad
    input  logic [1:0]  i_s_axis_tuser,   // kind[1:0]
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [31:0] i_m_axis_tdata,   // cursor_offset[10:0], cell_char[18:11],
                                          // cell_attribute[26:19], zero pad
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    output int          o_pending,
    output int          o_checked,
    output int          o_scrolls,
    output int          o_errors
);
    import tcw_pkg::*;

    localparam int MAX_PRINTED = 100;

    typedef struct packed {
        logic [CURS_W-1:0] cursor_offset;
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attribute;
    } t_console_reply;

    t_cell             screen [CELL_COUNT];
    int                cur_row;
    int                cur_col;
    logic [ATTR_W-1:0] text_attr;
    t_console_reply    awaited_replies [$];
    int                scroll_total;
    int                checked_total;
    int                error_total;

    function automatic void fill_screen(t_cell value);
        for (int i = 0; i < CELL_COUNT; i++) screen[i] = value;
    endfunction

    function automatic void advance_line();
        cur_col = 0;
        cur_row++;
    endfunction

    function automatic void put_code(logic [CHAR_W-1:0] code);
        t_cell blank;
        blank = {text_attr, BLANK_CHAR};
        if (code == CODE_NEWLINE) begin
            advance_line();
        end else if (code == CODE_TAB) begin
            cur_col = (cur_col + 4) & ~3;
            if (cur_col >= COLUMNS) advance_line();
        end else if (code == CODE_BACKSPACE) begin
            // At home the cursor stays put, yet the cell under it is still blanked.
            if (cur_col == 0) begin
                if (cur_row > 0) begin
                    cur_row--;
                    cur_col = COLUMNS - 1;
                end
            end else begin
                cur_col--;
            end
            screen[cur_row * COLUMNS + cur_col] = blank;
        end else begin
            screen[cur_row * COLUMNS + cur_col] = {text_attr, code};
            cur_col++;
            if (cur_col >= COLUMNS) advance_line();
        end
        // Falling off the bottom row scrolls everything up by one row.
        if (cur_row >= ROWS) begin
            for (int i = 0; i < CELL_COUNT - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
            for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) screen[i] = blank;
            cur_row = ROWS - 1;
            scroll_total++;
        end
    endfunction

    function automatic t_console_reply predict_reply(logic [KIND_W-1:0] kind,
                                                     logic [CHAR_W-1:0] code,
                                                     logic [ADDR_W-1:0] addr);
        t_console_reply reply;
        int             offset;
        reply = '0;
        if (kind == KIND_PUT) begin
            put_code(code);
        end else if (kind == KIND_CLEAR) begin
            fill_screen({text_attr, BLANK_CHAR});
            cur_row = 0;
            cur_col = 0;
        end else if (kind == KIND_READ && addr < CELL_COUNT) begin
            reply.cell_char      = screen[addr][CHAR_W-1:0];
            reply.cell_attribute = screen[addr][ATTR_W+CHAR_W-1:CHAR_W];
        end
        offset = cur_row * COLUMNS + cur_col;
        reply.cursor_offset = offset[CURS_W-1:0];
        return reply;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_total++;
        if (error_total <= MAX_PRINTED)
            $display("tcw_checker: %s wrong on result %0d at %0t: got 0x%0h, wanted 0x%0h",
                     what, checked_total, $realtime, got, want);
    endtask

    always @(posedge i_clk) begin
        t_console_reply got;
        t_console_reply want;
        if (!i_rst_n) begin
            fill_screen({RESET_ATTR, BLANK_CHAR});
            cur_row   = 0;
            cur_col   = 0;
            text_attr = RESET_ATTR;
            awaited_replies.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) text_attr = i_cfg_data;
            // A result leaves before the next command is predicted: on a shared
            // edge the result always belongs to the older command.
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.cursor_offset  = i_m_axis_tdata[10:0];
                got.cell_char      = i_m_axis_tdata[18:11];
                got.cell_attribute = i_m_axis_tdata[26:19];
                if (awaited_replies.size() == 0) begin
                    report_mismatch("result with no command", i_m_axis_tdata, '0);
                end else begin
                    want = awaited_replies.pop_front();
                    if (got.cursor_offset != want.cursor_offset)
                        report_mismatch("cursor_offset", 32'(got.cursor_offset),
                                        32'(want.cursor_offset));
                    if (got.cell_char != want.cell_char)
                        report_mismatch("cell_char", 32'(got.cell_char),
                                        32'(want.cell_char));
                    if (got.cell_attribute != want.cell_attribute)
                        report_mismatch("cell_attribute", 32'(got.cell_attribute),
                                        32'(want.cell_attribute));
                end
                checked_total++;
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                awaited_replies.push_back(predict_reply(i_s_axis_tuser, i_s_axis_tdata[7:0],
                                                        i_s_axis_tdata[18:8]));
        end
        o_pending <= awaited_replies.size();
        o_checked <= checked_total;
        o_scrolls <= scroll_total;
        o_errors  <= error_total;
    end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench top for the text console writer
// Drives a short directed command list and then three random phases with
// different attribute settings and back-pressure patterns; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import tcw_pkg::*;

    localparam int                HALF_PERIOD      = 6;
    localparam int                RANDOM_PER_PHASE = 150;
    localparam int                SETTLE_CYCLES    = CELL_COUNT + 100;
    localparam longint            LIMIT_TIME       = 60_000_000;
    localparam logic [KIND_W-1:0] KIND_UNUSED      = 2'd3;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // char_code[7:0], cell_address[18:8], zero pad
    logic [1:0]  s_axis_tuser  = '0;   // kind[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // cursor_offset[10:0], cell_char[18:11],
                                       // cell_attribute[26:19], zero pad
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data      = '0;

    int results_pending;
    int results_checked;
    int scrolls_seen;
    int mismatches;

    int send_idle_pct = 10;
    int recv_idle_pct = 77;
    int put_count;
    int read_count;
    int clear_count;
    int unused_count;
    int attr_writes;

    text_console_writer_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    tcw_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .o_pending       (results_pending),
        .o_checked       (results_checked),
        .o_scrolls       (scrolls_seen),
        .o_errors        (mismatches)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Valid stays high after an accepting edge, so back-to-back transfers
    // need no second assignment in the same step.
    task automatic send_command(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] code,
                                logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, addr, code};
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        case (kind)
            KIND_PUT:   put_count++;
            KIND_READ:  read_count++;
            KIND_CLEAR: clear_count++;
            default:    unused_count++;
        endcase
    endtask

    // Quiets the command channel and waits until no result is outstanding.
    task automatic write_attribute(logic [ATTR_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (results_pending != 0);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        attr_writes++;
    endtask

    task automatic send_random_command();
        int unsigned       pick;
        int unsigned       sel;
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] code;
        logic [ADDR_W-1:0] addr;
        pick = $urandom_range(999);
        code = CHAR_W'($urandom_range(255));
        addr = ADDR_W'($urandom_range(2047));
        if (pick < 5) begin
            kind = KIND_CLEAR;
        end else if (pick < 60) begin
            kind = KIND_UNUSED;
        end else if (pick < 260) begin
            kind = KIND_READ;
            sel  = $urandom_range(9);
            // Once the screen has scrolled, the fresh text sits in the bottom rows.
            if (sel < 4)
                addr = ADDR_W'($urandom_range(CELL_COUNT - 1, CELL_COUNT - 2 * COLUMNS));
            else if (sel < 6)
                addr = ADDR_W'($urandom_range(2 * COLUMNS - 1, 0));
        end else begin
            kind = KIND_PUT;
            sel  = $urandom_range(99);
            if (sel < 22) code = CODE_NEWLINE;
            else if (sel < 30) code = CODE_TAB;
            else if (sel < 38) code = CODE_BACKSPACE;
        end
        send_command(kind, code, addr);
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        write_attribute(8'hFF);
        // Reset contents and reads at and past the end of the store.
        send_command(KIND_READ, 8'h00, 11'd0);
        send_command(KIND_READ, 8'hFF, 11'd1999);
        send_command(KIND_READ, 8'h00, 11'd2000);
        send_command(KIND_READ, 8'hFF, 11'd2047);
        send_command(KIND_PUT, 8'h41, 11'd0);
        send_command(KIND_PUT, 8'h00, 11'h7FF);
        send_command(KIND_PUT, 8'hFF, 11'd0);
        // Newline then backspace lands on the last column of row 0; a tab
        // from there runs past the right edge onto the next row.
        send_command(KIND_PUT, CODE_NEWLINE, 11'd0);
        send_command(KIND_PUT, CODE_BACKSPACE, 11'd0);
        send_command(KIND_PUT, CODE_TAB, 11'd0);
        send_command(KIND_PUT, CODE_TAB, 11'd0);
        send_command(KIND_PUT, 8'h5A, 11'd0);
        send_command(KIND_PUT, CODE_BACKSPACE, 11'd0);
        send_command(KIND_UNUSED, 8'hFF, 11'h7FF);
        send_command(KIND_READ, 8'h00, 11'd1);
        send_command(KIND_READ, 8'h00, 11'd2);
        send_command(KIND_CLEAR, 8'h00, 11'd0);
        send_command(KIND_READ, 8'h00, 11'd79);
        send_command(KIND_PUT, CODE_BACKSPACE, 11'd0);
        send_command(KIND_READ, 8'h00, 11'd0);
        // An ordinary character in the last column wraps to the next row.
        send_command(KIND_PUT, CODE_NEWLINE, 11'd0);
        send_command(KIND_PUT, CODE_BACKSPACE, 11'd0);
        send_command(KIND_PUT, 8'h51, 11'd0);
        send_command(KIND_READ, 8'h00, 11'd79);

        write_attribute(8'h00);
        repeat (RANDOM_PER_PHASE) send_random_command();

        write_attribute(ATTR_W'($urandom_range(254, 1)));
        send_idle_pct = 77;
        recv_idle_pct = 10;
        repeat (RANDOM_PER_PHASE) send_random_command();

        write_attribute(RESET_ATTR);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (RANDOM_PER_PHASE) send_random_command();

        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (results_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Commands: %0d puts, %0d reads, %0d clears, %0d of the unused kind.",
                 put_count, read_count, clear_count, unused_count);
        $display("Results checked: %0d, screen scrolls: %0d, attribute writes: %0d.",
                 results_checked, scrolls_seen, attr_writes);
        if (mismatches == 0 && results_pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #(LIMIT_TIME);
        $display("Timed out with %0d results outstanding.", results_pending);
        $display("== FAIL ==");
        $finish;
    end

endmodule
